// ===== hw/rtl/uer_pkg.sv =====
// shared types, constants and helpers for the ultrasonic echo ranger
// no dependencies; imported by every module of the block
`default_nettype none

package uer_pkg;

    // width of the internal echo width counter
    localparam int TIME_BITS = 16;

    localparam int TRAVEL_W = 16;
    localparam int DIST_W   = 19;
    localparam int TICK_W   = 16;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    // distance = travel * 0.01715 * 256, as a 16 bit fraction
    localparam logic [DIST_W-1:0]    DIST_MUL   = 19'd287731;
    localparam logic [TRAVEL_W-1:0]  SIM_TRAVEL = 16'd10;
    localparam logic [TRAVEL_W-1:0]  TRAVEL_MAX = 16'hFFFF;
    localparam logic [TIME_BITS-1:0] WIDTH_MAX  = {TIME_BITS{1'b1}};
    localparam logic [DIST_W-1:0]    DIST_MAX   = 19'd287744;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TICKS    = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_TICKS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_WAIT_LIMIT = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SENSOR_BYPASS   = 8'd3;

    // configuration reset values
    localparam logic [15:0] SETTLE_RESET = 16'd10000;
    localparam logic [7:0]  TRIGGER_RESET = 8'd10;
    localparam logic [15:0] RISE_WAIT_RESET = 16'd23000;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_SETTLE = 3'd1,
        PH_TRIG   = 3'd2,
        PH_WAIT   = 3'd3,
        PH_MEAS   = 3'd4
    } phase_t;

    typedef struct packed {
        logic [15:0] settle_ticks;
        logic [7:0]  trigger_ticks;
        logic [15:0] rise_wait_limit;
        logic        sensor_bypass;
    } cfg_t;

    // per-tick result from the sequencer, before the distance product
    typedef struct packed {
        logic                trigger;
        logic                done;
        logic                timed_out;
        logic [TRAVEL_W-1:0] travel;
    } res_t;

    // clamp the echo width counter to the 16 bit travel field
    function automatic logic [TRAVEL_W-1:0] sat_travel(input logic [TIME_BITS-1:0] w);
        logic [31:0] wx;
        logic [TRAVEL_W-1:0] t;
        wx = 32'(w);
        if (wx >= 32'(TRAVEL_MAX)) begin
            t = TRAVEL_MAX;
        end else begin
            t = wx[TRAVEL_W-1:0];
        end
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// top level of the ultrasonic echo ranger
// depends on uer_pkg, uer_cfg_regs, uer_seq, uer_out
//
//  channel  | ports                                    | role
//  ---------+------------------------------------------+---------------------------
//  s_       | s_valid s_ready s_start_req s_echo_in    | one microsecond tick in
//  m_       | m_valid m_ready m_trigger_out m_done_res | one result per tick out
//           | m_timed_out m_travel_us m_distance_q8    |
//  cfg_     | cfg_valid cfg_ready cfg_index cfg_data   | register writes
//
// on each tick the sequencer updates its state on the input
// transaction and the result, with its 16x19 distance product, lands in the
// output register at the same edge. a new tick is taken every cycle while
// the result register is empty or being drained; a stalled m_ready holds
// s_ready low. synchronous active low reset returns to idle with the
// documented register defaults.
`default_nettype none

module ultrasonic_echo_ranger (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              s_valid,
    output logic                             s_ready,
    input  wire                              s_start_req,
    input  wire                              s_echo_in,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_trigger_out,
    output logic                             m_done_res,
    output logic                             m_timed_out,
    output logic [uer_pkg::TRAVEL_W-1:0]     m_travel_us,
    output logic [uer_pkg::DIST_W-1:0]       m_distance_q8,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [uer_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import uer_pkg::*;

    cfg_t cfg;
    res_t res;
    logic accept;

    assign s_ready = !m_valid || m_ready;
    assign accept  = s_valid && s_ready;

    uer_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uer_seq u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .start_req (s_start_req),
        .echo_in   (s_echo_in),
        .cfg       (cfg),
        .res       (res)
    );

    uer_out u_out (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .load          (accept),
        .res           (res),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_trigger_out (m_trigger_out),
        .m_done_res    (m_done_res),
        .m_timed_out   (m_timed_out),
        .m_travel_us   (m_travel_us),
        .m_distance_q8 (m_distance_q8)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/uer_cfg_regs.sv =====
// configuration register file for the ultrasonic echo ranger
// depends on uer_pkg
`default_nettype none

module uer_cfg_regs (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              cfg_valid,
    output logic                             cfg_ready,
    input  wire [uer_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire [uer_pkg::CFG_DATA_W-1:0]    cfg_data,
    output uer_pkg::cfg_t                    cfg
);
    import uer_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_SETTLE_TICKS:    cfg_next.settle_ticks    = cfg_data;
                CFG_TRIGGER_TICKS:   cfg_next.trigger_ticks   = cfg_data[7:0];
                CFG_RISE_WAIT_LIMIT: cfg_next.rise_wait_limit = cfg_data;
                CFG_SENSOR_BYPASS:   cfg_next.sensor_bypass   = cfg_data[0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.settle_ticks    <= SETTLE_RESET;
            cfg_reg.trigger_ticks   <= TRIGGER_RESET;
            cfg_reg.rise_wait_limit <= RISE_WAIT_RESET;
            cfg_reg.sensor_bypass   <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/uer_seq.sv =====
// measurement sequencer: phase state machine, tick and echo width counters
// depends on uer_pkg
`default_nettype none

module uer_seq (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            accept,
    input  wire            start_req,
    input  wire            echo_in,
    input  uer_pkg::cfg_t  cfg,
    output uer_pkg::res_t  res
);
    import uer_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     tick_reg, tick_next;
    logic [TIME_BITS-1:0]  width_reg, width_next;

    logic [TICK_W-1:0]     tick_inc;
    logic [TICK_W-1:0]     trig_w;

    assign tick_inc = tick_reg + 1'b1;
    // a zero trigger width still gives a one tick pulse
    assign trig_w   = (cfg.trigger_ticks == 8'd0) ? 16'd1 : 16'(cfg.trigger_ticks);

    always_comb begin
        phase_next = phase_reg;
        tick_next  = tick_reg;
        width_next = width_reg;
        res        = '0;
        unique case (phase_reg)
            PH_SETTLE: begin
                if (tick_reg < cfg.settle_ticks) begin
                    tick_next = tick_inc;
                end else if (cfg.sensor_bypass) begin
                    res.done   = 1'b1;
                    res.travel = SIM_TRAVEL;
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end else begin
                    phase_next = PH_TRIG;
                    tick_next  = '0;
                end
            end
            PH_TRIG: begin
                res.trigger = 1'b1;
                if (tick_inc >= trig_w) begin
                    phase_next = PH_WAIT;
                    tick_next  = '0;
                end else begin
                    tick_next = tick_inc;
                end
            end
            PH_WAIT: begin
                if (echo_in) begin
                    phase_next = PH_MEAS;
                    width_next = TIME_BITS'(1);
                    tick_next  = '0;
                end else if (tick_inc >= cfg.rise_wait_limit) begin
                    // echo never rose: report a timeout with zero travel
                    res.done      = 1'b1;
                    res.timed_out = 1'b1;
                    phase_next    = PH_IDLE;
                    tick_next     = '0;
                end else begin
                    tick_next = tick_inc;
                end
            end
            PH_MEAS: begin
                if (echo_in) begin
                    if (width_reg != WIDTH_MAX) begin
                        width_next = width_reg + 1'b1;
                    end
                end else begin
                    res.done   = 1'b1;
                    res.travel = sat_travel(width_reg);
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                end
            end
            default: begin
                // idle, and any unused phase code
                phase_next = PH_IDLE;
                if (start_req) begin
                    phase_next = PH_SETTLE;
                    tick_next  = '0;
                    width_next = '0;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            width_reg <= '0;
        end else if (accept) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            width_reg <= width_next;
        end
    end

    a_done_no_trigger: assert property (@(posedge aclk) disable iff (!aresetn)
        !(res.done && res.trigger))
        else $error("trigger driven on a completion tick");

    a_timeout_zero_travel: assert property (@(posedge aclk) disable iff (!aresetn)
        res.timed_out |-> (res.done && res.travel == '0))
        else $error("timeout without done or with nonzero travel");

    a_meas_width: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_MEAS |-> width_reg != '0)
        else $error("measure phase with empty echo width");

    a_finish_to_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && res.done) |=> (phase_reg == PH_IDLE && tick_reg == '0))
        else $error("completed measurement did not return to idle");

endmodule

`default_nettype wire

// ===== hw/rtl/uer_out.sv =====
// result register: distance product and output handshake stage
// depends on uer_pkg
`default_nettype none

module uer_out (
    input  wire                              aclk,
    input  wire                              aresetn,
    input  wire                              load,
    input  uer_pkg::res_t                    res,
    output logic                             m_valid,
    input  wire                              m_ready,
    output logic                             m_trigger_out,
    output logic                             m_done_res,
    output logic                             m_timed_out,
    output logic [uer_pkg::TRAVEL_W-1:0]     m_travel_us,
    output logic [uer_pkg::DIST_W-1:0]       m_distance_q8
);
    import uer_pkg::*;

    localparam int PROD_W = TRAVEL_W + DIST_W;

    logic                 m_valid_reg, m_valid_next;
    res_t                 res_reg;
    logic [DIST_W-1:0]    dist_reg;
    logic [PROD_W-1:0]    prod;

    assign prod = PROD_W'(res.travel) * PROD_W'(DIST_MUL);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg  <= res;
            dist_reg <= prod[PROD_W-1:16];
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_trigger_out = res_reg.trigger;
    assign m_done_res    = res_reg.done;
    assign m_timed_out   = res_reg.timed_out;
    assign m_travel_us   = res_reg.travel;
    assign m_distance_q8 = dist_reg;

    a_idle_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !res_reg.done) |-> (res_reg.travel == '0 && dist_reg == '0))
        else $error("travel or distance reported without done");

    a_dist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> dist_reg <= DIST_MAX)
        else $error("distance above full scale");

    a_timeout_dist: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && res_reg.timed_out) |-> dist_reg == '0)
        else $error("timeout with nonzero distance");

endmodule

`default_nettype wire

// ===== bench/tb_ultrasonic_echo_ranger.sv =====
`timescale 1ns / 100ps
// self-checking bench for ultrasonic_echo_ranger: drives one tick per transaction,
// predicts every per-tick result and checks it in order; needs uer_pkg and the rtl

module tb_ultrasonic_echo_ranger;
    import uer_pkg::*;

    localparam int unsigned RX_HOLD_CYCLES = 300;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned RANDOM_TICKS = 1150;
    localparam int unsigned PHASE_TICKS = 150;
    localparam int unsigned MAX_REPORTS = 10;
    // 0.01715 cm per us, times 256, as a 16 bit fraction
    localparam logic [63:0] CM_Q8_PER_US = 64'd287731;
    localparam logic [15:0] FAKE_TRAVEL = 16'd10;

    typedef struct packed {
        logic        trigger;
        logic        done;
        logic        timed_out;
        logic [15:0] travel;
        logic [18:0] distance;
    } tick_result_t;

    class range_checker;
        logic [15:0] settle_ticks;
        logic [7:0]  trigger_ticks;
        logic [15:0] rise_wait_limit;
        logic        sensor_bypass;
        phase_t      phase;
        logic [15:0] tick_count;
        logic [TIME_BITS-1:0] echo_width;
        tick_result_t expected_ticks[$];
        int unsigned results_seen;
        int unsigned errors;

        function new();
            settle_ticks = 16'd10000;
            trigger_ticks = 8'd10;
            rise_wait_limit = 16'd23000;
            sensor_bypass = 1'b0;
            phase = PH_IDLE;
            tick_count = '0;
            echo_width = '0;
            results_seen = 0;
            errors = 0;
        endfunction

        function void write_reg(logic [7:0] idx, logic [15:0] data);
            case (idx)
                CFG_SETTLE_TICKS:    settle_ticks = data;
                CFG_TRIGGER_TICKS:   trigger_ticks = data[7:0];
                CFG_RISE_WAIT_LIMIT: rise_wait_limit = data;
                CFG_SENSOR_BYPASS:   sensor_bypass = data[0];
                default: ;
            endcase
        endfunction

        // the distance follows the clamped travel time, not the raw count
        function tick_result_t close_measurement(logic [TIME_BITS-1:0] width, logic tmo);
            tick_result_t r;
            logic [63:0] t;
            logic [63:0] prod;
            t = 64'(width);
            if (t > 64'd65535) t = 64'd65535;
            prod = t * CM_Q8_PER_US;
            r = '0;
            r.done = 1'b1;
            r.timed_out = tmo;
            r.travel = t[15:0];
            r.distance = prod[34:16];
            phase = PH_IDLE;
            tick_count = '0;
            return r;
        endfunction

        function void take_tick(logic start, logic echo);
            tick_result_t r;
            logic [7:0] pulse;
            r = '0;
            case (phase)
                PH_SETTLE: begin
                    if (tick_count < settle_ticks) begin
                        tick_count = tick_count + 16'd1;
                    end else if (sensor_bypass) begin
                        r = close_measurement(FAKE_TRAVEL, 1'b0);
                    end else begin
                        phase = PH_TRIG;
                        tick_count = '0;
                    end
                end
                PH_TRIG: begin
                    pulse = (trigger_ticks == 8'd0) ? 8'd1 : trigger_ticks;
                    r.trigger = 1'b1;
                    tick_count = tick_count + 16'd1;
                    if (tick_count >= 16'(pulse)) begin
                        phase = PH_WAIT;
                        tick_count = '0;
                    end
                end
                PH_WAIT: begin
                    if (echo) begin
                        phase = PH_MEAS;
                        echo_width = 1;
                        tick_count = '0;
                    end else begin
                        tick_count = tick_count + 16'd1;
                        if (tick_count >= rise_wait_limit) r = close_measurement('0, 1'b1);
                    end
                end
                PH_MEAS: begin
                    if (echo) begin
                        if (echo_width != '1) echo_width = echo_width + 1'b1;
                    end else begin
                        r = close_measurement(echo_width, 1'b0);
                    end
                end
                default: begin
                    phase = PH_IDLE;
                    if (start) begin
                        phase = PH_SETTLE;
                        tick_count = '0;
                        echo_width = '0;
                    end
                end
            endcase
            expected_ticks.push_back(r);
        endfunction

        function void check_tick(tick_result_t got);
            tick_result_t want;
            if (expected_ticks.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("result with nothing expected: trig=%b done=%b tmo=%b travel=%0d dist=%0d",
                             got.trigger, got.done, got.timed_out, got.travel, got.distance);
                return;
            end
            want = expected_ticks.pop_front();
            results_seen++;
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS) begin
                    $display("result %0d mismatch", results_seen);
                    $display("  expected trig=%b done=%b tmo=%b travel=%0d dist=%0d",
                             want.trigger, want.done, want.timed_out, want.travel, want.distance);
                    $display("  actual   trig=%b done=%b tmo=%b travel=%0d dist=%0d",
                             got.trigger, got.done, got.timed_out, got.travel, got.distance);
                end
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_start_req = 1'b0;
    logic s_echo_in = 1'b0;
    logic s_ready;
    logic m_valid;
    logic m_ready = 1'b0;
    logic m_trigger_out;
    logic m_done_res;
    logic m_timed_out;
    logic [TRAVEL_W-1:0] m_travel_us;
    logic [DIST_W-1:0] m_distance_q8;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    range_checker sb;

    // what the stimulus side knows of the current settings, with zero widths made one
    int unsigned gen_settle = 10000;
    int unsigned gen_pulse = 10;
    int unsigned gen_limit = 23000;
    logic gen_sim = 1'b0;

    int unsigned ticks_sent = 0;
    int unsigned tx_idle_pct = 10;
    int unsigned rx_idle_pct = 46;
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int unsigned hold_left = 0;
    int unsigned stall_cycles = 0;

    always #1 aclk = ~aclk;

    ultrasonic_echo_ranger u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_req  (s_start_req),
        .s_echo_in    (s_echo_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_trigger_out(m_trigger_out),
        .m_done_res   (m_done_res),
        .m_timed_out  (m_timed_out),
        .m_travel_us  (m_travel_us),
        .m_distance_q8(m_distance_q8),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // result side: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != hold_requests) begin
            m_ready <= 1'b0;
            holds_served <= holds_served + 1;
            hold_left <= RX_HOLD_CYCLES;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_tick({m_trigger_out, m_done_res, m_timed_out, m_travel_us, m_distance_q8});
            if (s_valid && s_ready) sb.take_tick(s_start_req, s_echo_in);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic send_tick(logic start, logic echo);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_start_req <= start;
        s_echo_in <= echo;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        ticks_sent++;
    endtask

    // waits until every result is back, then writes all registers and one unused index
    task automatic reconfigure(logic [15:0] settle, logic [7:0] pulse, logic [15:0] limit,
                               logic sim);
        logic [7:0]  idx [5];
        logic [15:0] val [5];
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_ticks.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
        idx[0] = CFG_SETTLE_TICKS;
        val[0] = settle;
        idx[1] = CFG_TRIGGER_TICKS;
        val[1] = {8'($urandom), pulse};
        idx[2] = CFG_RISE_WAIT_LIMIT;
        val[2] = limit;
        idx[3] = CFG_SENSOR_BYPASS;
        val[3] = {15'($urandom), sim};
        idx[4] = 8'($urandom_range(255, CFG_SENSOR_BYPASS + 1));
        val[4] = 16'($urandom);
        for (int i = 0; i < 5; i++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data <= val[i];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            sb.write_reg(idx[i], val[i]);
        end
        cfg_valid <= 1'b0;
        gen_settle = settle;
        gen_pulse = (pulse == 8'd0) ? 1 : pulse;
        gen_limit = (limit == 16'd0) ? 1 : limit;
        gen_sim = sim;
    endtask

    // one start-to-done sequence; starts offered while busy are random, but for the caller's end_start
    task automatic run_measurement(logic tmo, int unsigned low_ticks, int unsigned high_ticks,
                                   logic end_start);
        send_tick(1'b1, 1'($urandom));
        if (gen_sim) begin
            repeat (gen_settle) send_tick(1'($urandom), 1'($urandom));
            send_tick(end_start, 1'($urandom));
        end else begin
            // echo is a don't care through settle and the trigger pulse
            repeat (gen_settle + 1 + gen_pulse) send_tick(1'($urandom), 1'($urandom));
            if (tmo) begin
                repeat (gen_limit - 1) send_tick(1'($urandom), 1'b0);
                send_tick(end_start, 1'b0);
            end else begin
                repeat (low_ticks) send_tick(1'($urandom), 1'b0);
                repeat (high_ticks) send_tick(1'($urandom), 1'b1);
                send_tick(end_start, 1'b0);
            end
        end
    endtask

    task automatic random_measurement();
        int unsigned low_ticks;
        int unsigned high_ticks;
        low_ticks = $urandom_range((gen_limit > 20) ? 19 : gen_limit - 1);
        high_ticks = ($urandom_range(3) == 0) ? 1 : $urandom_range(20, 1);
        if ($urandom_range(9) == 0) begin
            // garbage, then enough quiet ticks to reach idle from any phase
            repeat ($urandom_range(30, 1)) send_tick(1'($urandom), 1'($urandom));
            repeat (gen_settle + gen_pulse + gen_limit + 3) send_tick(1'b0, 1'b0);
        end else begin
            run_measurement($urandom_range(4) == 0, low_ticks, high_ticks, 1'($urandom));
        end
        repeat ($urandom_range(3)) send_tick(1'b0, 1'($urandom));
    endtask

    initial begin
        int unsigned rphase;
        int unsigned random_base;
        int unsigned phase_end;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset settings: a start leaves the trigger low through the long settle
        send_tick(1'b1, 1'($urandom));
        repeat (40) send_tick(1'($urandom), 1'($urandom));

        // low extremes and zero widths; quiet ticks finish the settle in progress
        reconfigure(16'd0, 8'd0, 16'd0, 1'b0);
        repeat (gen_settle + gen_pulse + gen_limit + 3) send_tick(1'b0, 1'b0);
        run_measurement(1'b1, 0, 0, 1'b1);
        run_measurement(1'b0, 0, 1, 1'b0);
        send_tick(1'b0, 1'b1);
        // sensor bypass
        reconfigure(16'd3, 8'd2, 16'd5, 1'b1);
        run_measurement(1'b0, 0, 0, 1'b1);
        send_tick(1'b0, 1'b0);

        random_base = ticks_sent;
        rphase = 0;
        while (ticks_sent - random_base < RANDOM_TICKS) begin
            case (rphase % 6)
                0: reconfigure(16'($urandom_range(12)), 8'($urandom_range(6, 1)),
                               16'($urandom_range(25, 1)), 1'b0);
                1: reconfigure(16'd0, 8'd1, 16'd1, 1'b0);
                2: reconfigure(16'($urandom_range(12)), 8'd255, 16'($urandom_range(25, 1)), 1'b0);
                3: reconfigure(16'($urandom_range(12)), 8'($urandom_range(6)),
                               16'($urandom_range(25)), 1'b1);
                4: reconfigure(16'($urandom_range(12)), 8'd0, 16'd0, 1'b0);
                default: reconfigure(16'($urandom_range(40)), 8'($urandom_range(20)),
                                     16'($urandom_range(60)), 1'($urandom));
            endcase
            if (ticks_sent - random_base > 2 * RANDOM_TICKS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end else if (ticks_sent - random_base > RANDOM_TICKS / 3) begin
                tx_idle_pct = 46;
                rx_idle_pct <= 10;
            end
            phase_end = ticks_sent + PHASE_TICKS;
            // long hold-off on the result side while ticks keep being offered
            if (rphase == 0) hold_requests <= hold_requests + 1;
            while (ticks_sent < phase_end) random_measurement();
            rphase++;
        end

        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_ticks.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_ticks.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
